FILE: hdl/hkdt_pkg.sv
// Shared types and constants for the hashed key dictionary table.
package hkdt_pkg;

   localparam int HASH_W       = 64;
   localparam int VAL_W        = 32;
   localparam int BYTE_W       = 8;
   localparam int COUNT_W      = 5;
   localparam int DEF_CAPACITY = 16;

   localparam logic [HASH_W-1:0] HASH_MULT = 64'h1F;

   typedef enum logic [1:0] {
      MODE_APPEND = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_GET    = 2'd2,
      MODE_SET    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_DONE    = 2'd0,
      STAT_MISSING = 2'd1,
      STAT_FULL    = 2'd2
   } status_type;

   // operation broadcast to every cell while a token walks the chain
   typedef struct packed {
      logic [HASH_W-1:0] key;
      mode_type          mode;
      logic [VAL_W-1:0]  data;
   } op_type;

   // token handed from cell to cell
   typedef struct packed {
      logic             active;
      logic             found;
      logic [VAL_W-1:0] value;
   } tok_type;

endpackage

FILE: hdl/hkdt_cell.sv
// One table entry: stored hash and value, plus the token stage it hands on.
module hkdt_cell #(
   parameter int CAP   = hkdt_pkg::DEF_CAPACITY,
   parameter int INDEX = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  hkdt_pkg::op_type                   op,
   input  logic [$clog2(CAP+1)-1:0]           fill,
   input  hkdt_pkg::tok_type                  tok_in,
   input  logic [hkdt_pkg::HASH_W-1:0]        nxt_hash,
   input  logic [hkdt_pkg::VAL_W-1:0]         nxt_value,
   output hkdt_pkg::tok_type                  tok_out,
   output logic [hkdt_pkg::HASH_W-1:0]        hash,
   output logic [hkdt_pkg::VAL_W-1:0]         value
);
   import hkdt_pkg::*;

   localparam int FW = $clog2(CAP+1);
   localparam logic [FW-1:0] IDX = FW'(INDEX);

   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [VAL_W-1:0]  value_ff, value_in;
   tok_type           tok_ff, tok_in_n;
   logic              occupied;
   logic              hit;

   assign occupied = IDX < fill;
   assign hit      = occupied && (hash_ff == op.key) && !tok_in.found;

   always_comb begin
      hash_in  = hash_ff;
      value_in = value_ff;
      tok_in_n = tok_in;
      if (tok_in.active) begin
         case (op.mode)
            MODE_APPEND: begin
               if (fill == IDX) begin
                  hash_in  = op.key;
                  value_in = op.data;
               end
            end
            MODE_REMOVE: begin
               // from the first match onwards each entry takes its neighbour's
               if (tok_in.found || hit) begin
                  hash_in        = nxt_hash;
                  value_in       = nxt_value;
                  tok_in_n.found = 1'b1;
               end
            end
            MODE_GET: begin
               if (hit) begin
                  tok_in_n.found = 1'b1;
                  tok_in_n.value = value_ff;
               end
            end
            MODE_SET: begin
               if (hit) begin
                  value_in       = op.data;
                  tok_in_n.found = 1'b1;
               end
            end
            default: begin
               tok_in_n = tok_in;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      hash_ff  <= hash_in;
      value_ff <= value_in;
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_n;
      end
   end

   assign tok_out = tok_ff;
   assign hash    = hash_ff;
   assign value   = value_ff;

endmodule

FILE: hdl/hashed_key_dictionary_table.sv
// Top level: key hashing, operation control and the chain of entry cells.
//
// Usage: key bytes arrive on the req_ channel, one beat per byte, and each
// nonzero byte folds into a 64-bit hash (hash*31 + byte). A beat with a zero
// key byte ends the key: req_mode picks append, remove, get or set, and
// req_data_in is the value for append and set. That beat launches a token
// through a chain of TABLE_CAPACITY entry cells, one cell per cycle; each
// cell compares its stored hash with the key, the first match acts, and on
// remove later entries move down one place as the token passes them.
// Nonzero key bytes are taken one per cycle while the table is idle. A
// terminating beat's token passes the launch register and each cell's token
// register before the rsp_ result register; no req_ beat is taken in the walk.
// The result sits in an output register; the next key may start streaming
// while it waits. If the receiver stalls when a walk ends, the result is
// held and req_ready stays low until the output register frees.
// Reset empties the table and clears the hash; no clearing pass is needed.
module hashed_key_dictionary_table #(
   parameter int TABLE_CAPACITY = hkdt_pkg::DEF_CAPACITY
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_mode,
   input  logic [hkdt_pkg::BYTE_W-1:0]        req_key_byte,
   input  logic [hkdt_pkg::VAL_W-1:0]         req_data_in,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_status,
   output logic [hkdt_pkg::VAL_W-1:0]         rsp_value_out,
   output logic [hkdt_pkg::COUNT_W-1:0]       rsp_entry_count
);
   import hkdt_pkg::*;

   localparam int CAP = TABLE_CAPACITY;
   localparam int FW  = $clog2(CAP+1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [HASH_W-1:0] hash_ff, hash_in;
   op_type            op_ff, op_in;
   logic [FW-1:0]     fill_ff, fill_in;
   logic              launch_ff, launch_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [VAL_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   status_type         pend_status_ff, pend_status_in;
   logic [VAL_W-1:0]   pend_value_ff, pend_value_in;
   logic [COUNT_W-1:0] pend_count_ff, pend_count_in;

   tok_type           tok [0:CAP];
   logic [HASH_W-1:0] cell_hash [0:CAP-1];
   logic [VAL_W-1:0]  cell_value [0:CAP-1];
   logic [CAP-1:0]    tok_active;

   logic              req_fire;
   logic              out_free;
   status_type        res_status;
   logic [VAL_W-1:0]  res_value;
   logic [FW-1:0]     res_fill;
   tok_type           tok_end;

   assign tok[0]   = '{active: launch_ff, found: 1'b0, value: '0};
   assign tok_end  = tok[CAP];
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   genvar gi;
   generate
      for (gi = 0; gi < CAP; gi++) begin : g_cell
         localparam int NXT = (gi == CAP-1) ? gi : gi + 1;
         hkdt_cell #(
            .CAP   (CAP),
            .INDEX (gi)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .op        (op_ff),
            .fill      (fill_ff),
            .tok_in    (tok[gi]),
            .nxt_hash  (cell_hash[NXT]),
            .nxt_value (cell_value[NXT]),
            .tok_out   (tok[gi+1]),
            .hash      (cell_hash[gi]),
            .value     (cell_value[gi])
         );
         assign tok_active[gi] = tok[gi+1].active;
      end
   endgenerate

   // outcome once the token leaves the last cell
   always_comb begin
      res_status = STAT_DONE;
      res_value  = '0;
      res_fill   = fill_ff;
      case (op_ff.mode)
         MODE_APPEND: begin
            if (fill_ff >= FW'(CAP)) begin
               res_status = STAT_FULL;
            end else begin
               res_fill = fill_ff + FW'(1);
            end
         end
         MODE_REMOVE: begin
            if (tok_end.found) begin
               res_fill = fill_ff - FW'(1);
            end else begin
               res_status = STAT_MISSING;
            end
         end
         MODE_GET: begin
            if (tok_end.found) begin
               res_value = tok_end.value;
            end else begin
               res_status = STAT_MISSING;
            end
         end
         MODE_SET: begin
            if (!tok_end.found) begin
               res_status = STAT_MISSING;
            end
         end
         default: begin
            res_status = STAT_DONE;
         end
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      hash_in        = hash_ff;
      op_in          = op_ff;
      fill_in        = fill_ff;
      launch_in      = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_count_in   = rsp_count_ff;
      pend_status_in = pend_status_ff;
      pend_value_in  = pend_value_ff;
      pend_count_in  = pend_count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_key_byte != '0) begin
                  // hash*31 as shift and subtract
                  hash_in = (hash_ff << 5) - hash_ff + HASH_W'(req_key_byte);
               end else begin
                  op_in     = '{key: hash_ff, mode: mode_type'(req_mode), data: req_data_in};
                  hash_in   = '0;
                  launch_in = 1'b1;
                  state_in  = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (tok_end.active) begin
               fill_in = res_fill;
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = res_status;
                  rsp_value_in  = res_value;
                  rsp_count_in  = COUNT_W'(res_fill);
                  state_in      = ST_IDLE;
               end else begin
                  pend_status_in = res_status;
                  pend_value_in  = res_value;
                  pend_count_in  = COUNT_W'(res_fill);
                  state_in       = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_value_in  = pend_value_ff;
               rsp_count_in  = pend_count_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_count_ff   <= rsp_count_in;
      pend_status_ff <= pend_status_in;
      pend_value_ff  <= pend_value_in;
      pend_count_ff  <= pend_count_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         hash_ff      <= '0;
         fill_ff      <= '0;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         fill_ff      <= fill_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_value_out   = rsp_value_ff;
   assign rsp_entry_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(CAP))
      else $error("fill count beyond capacity");

   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0({tok_active, launch_ff}))
      else $error("more than one token in the chain");

   a_token_in_walk: assert property (@(posedge clock) disable iff (reset)
      (launch_ff || tok_active != '0) |-> state_ff == ST_WALK)
      else $error("token moving outside a walk");

   a_term_launch: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_key_byte == '0) |=> (launch_ff && hash_ff == '0))
      else $error("terminator did not launch a walk");

   a_walk_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && tok_end.active && out_free) |=> rsp_valid_ff)
      else $error("walk ended without a result beat");
`endif

endmodule

FILE: verif/hashed_key_dictionary_table_tb.sv
`timescale 1ns / 100ps
// Testbench for the hashed key dictionary table: directed and random key streams, checked live.
module hashed_key_dictionary_table_tb;
   import hkdt_pkg::*;

   localparam int CAPACITY   = DEF_CAPACITY;
   localparam int POOL_SIZE  = 12;
   localparam int MAX_CYCLES = 400000;

   typedef struct packed {
      status_type             status;
      logic [VAL_W-1:0]       value;
      logic [COUNT_W-1:0]     count;
   } table_reply_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [1:0]           req_mode;
   logic [BYTE_W-1:0]    req_key_byte;
   logic [VAL_W-1:0]     req_data_in;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [1:0]           rsp_status;
   logic [VAL_W-1:0]     rsp_value_out;
   logic [COUNT_W-1:0]   rsp_entry_count;

   // predicted state of the table
   logic [HASH_W-1:0]    key_hash_acc;
   logic [HASH_W-1:0]    table_hash [CAPACITY];
   logic [VAL_W-1:0]     table_value [CAPACITY];
   int                   table_fill;

   table_reply_type      pending_replies [$];
   int                   mismatch_count;
   int                   cycle_count;
   int                   beats_sent;
   int                   send_idle_pct;
   int                   recv_idle_pct;
   int                   hold_left;

   logic [255:0]         pool_key [POOL_SIZE];
   int                   pool_len [POOL_SIZE];

   hashed_key_dictionary_table #(
      .TABLE_CAPACITY (CAPACITY)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_key_byte    (req_key_byte),
      .req_data_in     (req_data_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_value_out   (rsp_value_out),
      .rsp_entry_count (rsp_entry_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Folds one accepted beat into the predicted table and queues any reply.
   function automatic void predict_table_beat(mode_type m, logic [BYTE_W-1:0] kb,
                                              logic [VAL_W-1:0] d);
      logic [HASH_W-1:0] h;
      int                hit;
      table_reply_type   r;
      if (kb != 8'd0) begin
         key_hash_acc = key_hash_acc * HASH_MULT + {{(HASH_W-BYTE_W){1'b0}}, kb};
         return;
      end
      h = key_hash_acc;
      key_hash_acc = '0;
      hit = table_fill;
      for (int i = table_fill - 1; i >= 0; i--)
         if (table_hash[i] == h) hit = i;
      r.status = STAT_DONE;
      r.value  = '0;
      case (m)
         MODE_APPEND: begin
            if (table_fill >= CAPACITY) begin
               r.status = STAT_FULL;
            end else begin
               table_hash[table_fill]  = h;
               table_value[table_fill] = d;
               table_fill++;
            end
         end
         MODE_REMOVE: begin
            if (hit >= table_fill) begin
               r.status = STAT_MISSING;
            end else begin
               for (int j = hit; j + 1 < table_fill; j++) begin
                  table_hash[j]  = table_hash[j+1];
                  table_value[j] = table_value[j+1];
               end
               table_fill--;
            end
         end
         MODE_GET: begin
            if (hit >= table_fill) r.status = STAT_MISSING;
            else r.value = table_value[hit];
         end
         default: begin
            if (hit >= table_fill) r.status = STAT_MISSING;
            else table_value[hit] = d;
         end
      endcase
      r.count = table_fill[COUNT_W-1:0];
      pending_replies.push_back(r);
   endfunction

   task automatic send_beat(mode_type m, logic [BYTE_W-1:0] kb, logic [VAL_W-1:0] d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_mode     <= m;
      req_key_byte <= kb;
      req_data_in  <= d;
      do @(posedge clock); while (!req_ready);
      predict_table_beat(m, kb, d);
      beats_sent++;
   endtask

   // Key bytes go low byte first; filler beats carry random mode and data.
   task automatic send_key(mode_type m, logic [VAL_W-1:0] d, int len, logic [255:0] key);
      for (int i = 0; i < len; i++)
         send_beat(mode_type'($urandom_range(3)), key[8*i +: 8], $urandom);
      send_beat(m, 8'd0, d);
   endtask

   task automatic test_directed();
      send_key(MODE_GET,    32'h1234_5678, 0, '0);
      send_key(MODE_REMOVE, 32'h0,         0, '0);
      send_key(MODE_SET,    32'hDEAD_BEEF, 0, '0);
      send_key(MODE_APPEND, 32'hFFFF_FFFF, 0, '0);
      send_key(MODE_GET,    32'h0,         0, '0);
      send_key(MODE_APPEND, 32'h0,         2, 256'h6141);   // "Aa"
      send_key(MODE_GET,    32'h0,         2, 256'h4242);   // "BB" collides with "Aa"
      send_key(MODE_SET,    32'h5A5A_A5A5, 2, 256'h4242);
      send_key(MODE_APPEND, 32'h0000_0001, 2, 256'h6141);
      send_key(MODE_REMOVE, 32'h0,         0, '0);
      send_key(MODE_GET,    32'hFFFF_FFFF, 2, 256'h6141);
      send_key(MODE_GET,    32'h0,         1, 256'hFF);
   endtask

   task automatic test_long_keys();
      send_key(MODE_APPEND, 32'hA5A5_0F0F, 24, 256'({24{8'hFF}}));
      send_key(MODE_APPEND, 32'h0F0F_A5A5, 16, 256'({16{8'h01}}));
      send_key(MODE_GET,    32'h0,         24, 256'({24{8'hFF}}));
      send_key(MODE_GET,    32'h0,         16, 256'({16{8'h01}}));
      send_key(MODE_REMOVE, 32'h0,         24, 256'({24{8'hFF}}));
      send_key(MODE_GET,    32'h0,         24, 256'({24{8'hFF}}));
      send_key(MODE_REMOVE, 32'h0,         16, 256'({16{8'h01}}));
   endtask

   task automatic test_fill_and_drain();
      for (int k = 1; k <= CAPACITY + 2; k++)
         send_key(MODE_APPEND, $urandom, 1, 256'(k));
      send_key(MODE_GET,    32'h0,  1, 256'(CAPACITY / 2));
      send_key(MODE_SET,    $urandom, 1, 256'(CAPACITY));
      send_key(MODE_REMOVE, 32'h0,  1, 256'(CAPACITY / 2));
      send_key(MODE_REMOVE, 32'h0,  1, 256'(1));
      send_key(MODE_REMOVE, 32'h0,  1, 256'(CAPACITY));
      send_key(MODE_APPEND, $urandom, 1, 256'(8'h80));
      for (int k = 1; k <= CAPACITY; k++)
         send_key(MODE_REMOVE, 32'h0, 1, 256'(k));
      send_key(MODE_REMOVE, 32'h0,  1, 256'(8'h80));
      send_key(MODE_GET,    32'h0,  1, 256'(8'h80));
   endtask

   // receiver holds off long enough for a result to back up into the input
   task automatic test_output_stall();
      hold_left = 300;
      for (int k = 0; k < 6; k++)
         send_key(k[0] ? MODE_GET : MODE_APPEND, $urandom, 2, 256'(16'h4242 + k));
   endtask

   task automatic test_random(int beat_goal);
      int stop_at;
      int p;
      int len;
      int app_w;
      logic [255:0] key;
      mode_type m;
      stop_at = beats_sent + beat_goal;
      while (beats_sent < stop_at) begin
         if ($urandom_range(99) < 85) begin
            p   = $urandom_range(POOL_SIZE - 1);
            key = pool_key[p];
            len = pool_len[p];
         end else begin
            len = $urandom_range(16);
            for (int i = 0; i < 32; i++) key[8*i +: 8] = 8'($urandom_range(255, 1));
         end
         app_w = (table_fill < CAPACITY / 2) ? 50 : 30;
         if ($urandom_range(99) < app_w) m = MODE_APPEND;
         else m = mode_type'($urandom_range(3, 1));
         send_key(m, $urandom, len, key);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : reply_check
      table_reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_replies.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected reply status=%0d value=%h count=%0d", $time,
                        rsp_status, rsp_value_out, rsp_entry_count);
         end else begin
            want = pending_replies.pop_front();
            if (rsp_status !== want.status || rsp_value_out !== want.value ||
                rsp_entry_count !== want.count) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: reply mismatch exp status=%0d value=%h count=%0d, got %0d %h %0d",
                           $time, want.status, want.value, want.count,
                           rsp_status, rsp_value_out, rsp_entry_count);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > MAX_CYCLES) begin
         $display("** hashed_key_dictionary_table: FAILED **");
         $finish;
      end
   end

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_mode       <= MODE_APPEND;
      req_key_byte   <= '0;
      req_data_in    <= '0;
      key_hash_acc    = '0;
      table_fill      = 0;
      mismatch_count  = 0;
      cycle_count     = 0;
      beats_sent      = 0;
      hold_left       = 0;
      send_idle_pct   = 16;
      recv_idle_pct   = 57;
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_len[i] = $urandom_range(6);
         for (int b = 0; b < 32; b++) pool_key[i][8*b +: 8] = 8'($urandom_range(255, 1));
      end
      pool_key[0] = 256'h6141;
      pool_len[0] = 2;
      pool_key[1] = 256'h4242;
      pool_len[1] = 2;
      pool_len[2] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_long_keys();
      test_fill_and_drain();
      test_random(340);

      send_idle_pct = 57;
      recv_idle_pct = 16;
      test_output_stall();
      test_random(340);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(340);

      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (CAPACITY + 4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** hashed_key_dictionary_table: PASSED **");
      end else begin
         $display("** hashed_key_dictionary_table: FAILED **");
      end
      $finish;
   end

endmodule
